// ===== sv/mip_level_downsampler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mip level downsampler
// Shorthand for clocked assertions that use clk_i and rst_ni of the
// enclosing scope.
// ----------------------------------------------------------------------------
`ifndef MIP_LEVEL_DOWNSAMPLER_TOP_ASSERT_SVH
`define MIP_LEVEL_DOWNSAMPLER_TOP_ASSERT_SVH

// The condition holds at every clock edge, reset included.
`define MIP_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) (cond)) else $error(msg);

// The consequence holds in the same cycle, outside reset.
`define MIP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequence holds in the following cycle, outside reset.
`define MIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mip_pkg.sv =====
// ----------------------------------------------------------------------------
// Mip level downsampler package
// Shared types and fixed constants of the downsampler.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned FieldW      = 10;
  localparam int unsigned NumChan     = 4;
  localparam int unsigned PixelW      = ChanW * NumChan;
  localparam int unsigned EntryW      = FieldW * NumChan;
  localparam int unsigned SizeW       = 13;
  localparam int unsigned RowW        = 12;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned MinSize     = 2;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned WorkDepth   = 4;
  localparam int unsigned ResultDepth = 4;

  localparam logic [SizeW-1:0] ResetSrcWidth  = SizeW'(2);
  localparam logic [SizeW-1:0] ResetSrcHeight = SizeW'(2);
  localparam logic             ResetBoxMode   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_BOX_MODE   = 2'd2
  } mip_reg_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } mip_op_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } mip_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
    logic             last_pixel;
  } mip_out_t;

  typedef struct packed {
    mip_op_e           op;
    logic              box;
    logic              last_row;
    logic              last_pixel;
    logic [EntryW-1:0] data;
  } mip_work_t;

endpackage

// ===== sv/mip_level_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// Mip level downsampler
// Builds the next mip level of one RGBA8 slice from a raster pixel stream.
// ----------------------------------------------------------------------------
// Source pixels enter through push/full in raster order, one transfer per
// pixel. Output pixels of the half-size level leave through empty/pop in
// raster order, with last_pixel marking the final pixel of a frame.
// Registers src_width, src_height and box_mode are written through
// cfg_we_i/cfg_idx_i/cfg_data_i. The user must write them only while no
// frame is in flight; the block itself does not enforce this.
// Throughput is one source pixel per cycle while full is low. A result
// passes through the work queue, the line store read and the result queue.
// The line store holds MAX_WIDTH/2 entries of pair sums or picked pixels.
// Reset clears the counters, the queues and the registers; the line store
// needs no clearing since each entry is written before it is read.
// When pop stays low the result queue fills, the back end stops taking work,
// the work queue fills and full rises, so no transfer is lost.
module mip_level_downsampler_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  mip_pkg::mip_in_t                    pixel_i,
  output logic                                empty,
  input  logic                                pop,
  output mip_pkg::mip_out_t                   result_o,
  input  logic                                cfg_we_i,
  input  logic [mip_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [mip_pkg::SizeW-1:0]           cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(MAX_WIDTH / 2);
  localparam int unsigned WorkW  = IdxW + $bits(mip_pkg::mip_work_t);
  localparam int unsigned WCntW  = $clog2(mip_pkg::WorkDepth + 1);

  logic [mip_pkg::SizeW-1:0] src_width_q, src_width_d;
  logic [mip_pkg::SizeW-1:0] src_height_q, src_height_d;
  logic                      box_mode_q, box_mode_d;

  logic                      accept;
  logic                      fe_valid;
  mip_pkg::mip_work_t        fe_work;
  logic [IdxW-1:0]           fe_idx;
  logic                      mid_empty, mid_pop;
  logic [WorkW-1:0]          mid_rdata;
  mip_pkg::mip_work_t        be_work;
  logic [IdxW-1:0]           be_idx;
  logic [WCntW-1:0]          mid_count;

  always_comb begin
    src_width_d  = src_width_q;
    src_height_d = src_height_q;
    box_mode_d   = box_mode_q;
    if (cfg_we_i) begin
      unique case (mip_pkg::mip_reg_e'(cfg_idx_i))
        mip_pkg::REG_SRC_WIDTH:  src_width_d  = cfg_data_i;
        mip_pkg::REG_SRC_HEIGHT: src_height_d = cfg_data_i;
        mip_pkg::REG_BOX_MODE:   box_mode_d   = cfg_data_i[0];
        default:                 box_mode_d   = box_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= mip_pkg::ResetSrcWidth;
      src_height_q <= mip_pkg::ResetSrcHeight;
      box_mode_q   <= mip_pkg::ResetBoxMode;
    end else begin
      src_width_q  <= src_width_d;
      src_height_q <= src_height_d;
      box_mode_q   <= box_mode_d;
    end
  end

  assign accept = push && !full;

  mip_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .box_mode_i   (box_mode_q),
    .accept_i     (accept),
    .pixel_i      (pixel_i),
    .work_valid_o (fe_valid),
    .work_o       (fe_work),
    .work_idx_o   (fe_idx)
  );

  mip_fifo #(
    .DATA_W (WorkW),
    .DEPTH  (mip_pkg::WorkDepth)
  ) u_work_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .data_i  ({fe_idx, fe_work}),
    .full_o  (full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rdata),
    .count_o (mid_count)
  );

  assign {be_idx, be_work} = mid_rdata;

  mip_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (!mid_empty),
    .work_i       (be_work),
    .work_idx_i   (be_idx),
    .work_pop_o   (mid_pop),
    .res_empty_o  (empty),
    .res_pop_i    (pop),
    .res_o        (result_o)
  );

  // Occupancy of the work queue is only of interest in simulation.
  logic unused_count;
  assign unused_count = ^mid_count;

endmodule

// ===== sv/mip_fifo.sv =====
// ----------------------------------------------------------------------------
// Mip small queue
// Register-based first-in first-out queue with an occupancy count.
// ----------------------------------------------------------------------------
module mip_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [DATA_W-1:0]          data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/mip_front.sv =====
// ----------------------------------------------------------------------------
// Mip front end
// Tracks the source position, holds the left pixel of each pair and turns
// every right pixel of a used block into a store or emit work item.
// ----------------------------------------------------------------------------
module mip_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [mip_pkg::SizeW-1:0]                src_width_i,
  input  logic [mip_pkg::SizeW-1:0]                src_height_i,
  input  logic                                     box_mode_i,
  input  logic                                     accept_i,
  input  mip_pkg::mip_in_t                         pixel_i,
  output logic                                     work_valid_o,
  output mip_pkg::mip_work_t                       work_o,
  output logic [$clog2(MAX_WIDTH / 2)-1:0]         work_idx_o
);

  localparam int unsigned ColW       = $clog2(MAX_WIDTH);
  localparam int unsigned StoreDepth = MAX_WIDTH / 2;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned FitW       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WideW      = (FitW > mip_pkg::SizeW) ? FitW : mip_pkg::SizeW;
  localparam int unsigned SizeW      = mip_pkg::SizeW;
  localparam int unsigned RowW       = mip_pkg::RowW;
  localparam int unsigned ChanW      = mip_pkg::ChanW;
  localparam int unsigned FieldW     = mip_pkg::FieldW;
  localparam int unsigned NumChan    = mip_pkg::NumChan;

  logic [ColW-1:0]                  x_q, x_d;
  logic [RowW-1:0]                  y_q, y_d;
  logic [NumChan-1:0][ChanW-1:0]    left_q, left_d;
  logic [NumChan-1:0][ChanW-1:0]    cur_ch, pick_ch;
  logic [WideW-1:0]                 w_raw, w_clamp, w_even, x_ext, x_inc;
  logic [SizeW-1:0]                 h_clamp, h_even, y_ext, y_inc;
  logic                             in_block, last_col, last_row;
  logic [mip_pkg::EntryW-1:0]       data;

  assign cur_ch = {pixel_i.alpha, pixel_i.blue, pixel_i.green, pixel_i.red};

  always_comb begin
    w_raw = WideW'(src_width_i);
    priority if (w_raw < WideW'(mip_pkg::MinSize)) begin
      w_clamp = WideW'(mip_pkg::MinSize);
    end else if (w_raw > WideW'(MAX_WIDTH)) begin
      w_clamp = WideW'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    priority if (src_height_i < SizeW'(mip_pkg::MinSize)) begin
      h_clamp = SizeW'(mip_pkg::MinSize);
    end else if (src_height_i > SizeW'(mip_pkg::HeightLimit)) begin
      h_clamp = SizeW'(mip_pkg::HeightLimit);
    end else begin
      h_clamp = src_height_i;
    end
  end

  assign w_even   = {w_clamp[WideW-1:1], 1'b0};
  assign h_even   = {h_clamp[SizeW-1:1], 1'b0};
  assign x_ext    = WideW'(x_q);
  assign y_ext    = SizeW'(y_q);
  assign x_inc    = x_ext + WideW'(1);
  assign y_inc    = y_ext + SizeW'(1);
  assign in_block = (x_ext < w_even) && (y_ext < h_even);
  assign last_col = (x_ext == w_even - WideW'(1));
  assign last_row = (y_ext == h_even - SizeW'(1));
  assign pick_ch  = last_col ? cur_ch : left_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (box_mode_i) begin
        data[c*FieldW +: FieldW] = FieldW'(left_q[c]) + FieldW'(cur_ch[c]);
      end else begin
        data[c*FieldW +: FieldW] = FieldW'(pick_ch[c]);
      end
    end
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    left_d = left_q;
    if (accept_i) begin
      if (in_block && !x_q[0]) begin
        left_d = cur_ch;
      end
      if (x_inc >= w_clamp) begin
        x_d = '0;
        y_d = (y_inc >= h_clamp) ? '0 : y_inc[RowW-1:0];
      end else begin
        x_d = x_inc[ColW-1:0];
      end
    end
  end

  assign work_valid_o      = accept_i && in_block && x_q[0];
  assign work_idx_o        = x_q[IdxW:1];
  assign work_o.op         = y_q[0] ? mip_pkg::OP_EMIT : mip_pkg::OP_STORE;
  assign work_o.box        = box_mode_i;
  assign work_o.last_row   = last_row;
  assign work_o.last_pixel = last_row && last_col;
  assign work_o.data       = data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      left_q <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      left_q <= left_d;
    end
  end

endmodule

// ===== sv/mip_back.sv =====
// ----------------------------------------------------------------------------
// Mip back end
// Executes work items against the upper row store and finishes each output
// pixel into the result queue.
// ----------------------------------------------------------------------------
module mip_back #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              work_valid_i,
  input  mip_pkg::mip_work_t                work_i,
  input  logic [$clog2(MAX_WIDTH / 2)-1:0]  work_idx_i,
  output logic                              work_pop_o,
  output logic                              res_empty_o,
  input  logic                              res_pop_i,
  output mip_pkg::mip_out_t                 res_o
);

  localparam int unsigned StoreDepth = MAX_WIDTH / 2;
  localparam int unsigned ResDepth   = mip_pkg::ResultDepth;
  localparam int unsigned CntW       = $clog2(ResDepth + 1);
  localparam int unsigned EntryW     = mip_pkg::EntryW;
  localparam int unsigned FieldW     = mip_pkg::FieldW;
  localparam int unsigned ChanW      = mip_pkg::ChanW;
  localparam int unsigned NumChan    = mip_pkg::NumChan;

  logic [EntryW-1:0]             store_mem [StoreDepth];
  logic [EntryW-1:0]             rd_q;
  mip_pkg::mip_work_t            s1_q;
  logic                          s1_valid_q, s1_valid_d;
  logic                          issue, credit;
  logic [CntW-1:0]               res_count;
  logic [NumChan-1:0][ChanW-1:0] res_ch;
  logic [FieldW-1:0]             e_f, d_f, sum_f;
  mip_pkg::mip_out_t             res_d;
  logic                          res_full;

  assign credit     = (CntW'(res_count) + CntW'(s1_valid_q)) < CntW'(ResDepth);
  assign issue      = work_valid_i && credit;
  assign work_pop_o = issue;
  assign s1_valid_d = issue && (work_i.op == mip_pkg::OP_EMIT);

  always_ff @(posedge clk_i) begin
    if (issue && (work_i.op == mip_pkg::OP_STORE)) begin
      store_mem[work_idx_i] <= work_i.data;
    end
    if (s1_valid_d) begin
      rd_q <= store_mem[work_idx_i];
      s1_q <= work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_comb begin
    e_f   = '0;
    d_f   = '0;
    sum_f = '0;
    for (int c = 0; c < NumChan; c++) begin
      e_f   = rd_q[c*FieldW +: FieldW];
      d_f   = s1_q.data[c*FieldW +: FieldW];
      sum_f = e_f + d_f;
      if (s1_q.box) begin
        res_ch[c] = sum_f[FieldW-1:2];
      end else if (s1_q.last_row) begin
        res_ch[c] = d_f[ChanW-1:0];
      end else begin
        res_ch[c] = e_f[ChanW-1:0];
      end
    end
  end

  assign res_d.red_out    = res_ch[0];
  assign res_d.green_out  = res_ch[1];
  assign res_d.blue_out   = res_ch[2];
  assign res_d.alpha_out  = res_ch[3];
  assign res_d.last_pixel = s1_q.last_pixel;

  mip_fifo #(
    .DATA_W ($bits(mip_pkg::mip_out_t)),
    .DEPTH  (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .empty_o (res_empty_o),
    .data_o  (res_o),
    .count_o (res_count)
  );

  // The credit check keeps the result queue from ever overflowing.
  logic unused_full;
  assign unused_full = res_full;

endmodule

// ===== sv/mip_chk.sv =====
// ----------------------------------------------------------------------------
// Mip downsampler port checker
// Checks the queue-style ports of the downsampler over time.
// ----------------------------------------------------------------------------
`include "mip_level_downsampler_top_assert.svh"

module mip_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input mip_pkg::mip_out_t result_o
);

  `MIP_ASSERT_NOW(a_reset_empty, rst_ni || empty, "Result queue not empty during reset.")
  `MIP_ASSERT_NOW(a_reset_not_full, rst_ni || !full, "Input side full during reset.")
  `MIP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result_o), "Stalled result changed.")
  `MIP_ASSERT_IMPL(a_full_needs_push, $rose(full), $past(push), "Full rose without a transfer.")

endmodule

bind mip_level_downsampler_top mip_chk u_mip_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== dv/mip_level_downsampler_top_tb.sv =====
// ----------------------------------------------------------------------------
// Mip level downsampler testbench
// Streams raster frames of RGBA8 pixels into the downsampler under random
// idling on both sides and checks every output pixel against a line-store
// predictor kept in a scoreboard. Frame sizes, box and point mode, size
// clamping, dropped odd columns and rows and mid-frame register writes
// are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mip_level_downsampler_top_tb;

  localparam int unsigned ClkPeriod       = 20;
  localparam int unsigned TbMaxWidth      = 4096;
  localparam int unsigned StoreDepth      = TbMaxWidth / 2;
  localparam int unsigned SettleCycles    = 4;
  localparam int unsigned StallLimit      = 2000;
  localparam int unsigned RandomPixels    = 1450;
  localparam int unsigned ShownMismatches = 10;

  class mip_scoreboard;
    logic [mip_pkg::EntryW-1:0] upper_row [StoreDepth];
    logic [mip_pkg::ChanW-1:0]  left_chan [mip_pkg::NumChan];
    int unsigned                col;
    int unsigned                row;
    logic [mip_pkg::SizeW-1:0]  width_reg;
    logic [mip_pkg::SizeW-1:0]  height_reg;
    logic                       box_reg;
    mip_pkg::mip_out_t          pending_q [$];
    int unsigned                mismatches;

    function new();
      for (int c = 0; c < mip_pkg::NumChan; c++) left_chan[c] = '0;
      col        = 0;
      row        = 0;
      width_reg  = mip_pkg::ResetSrcWidth;
      height_reg = mip_pkg::ResetSrcHeight;
      box_reg    = mip_pkg::ResetBoxMode;
      mismatches = 0;
    endfunction

    function void set_reg(mip_pkg::mip_reg_e idx, logic [mip_pkg::SizeW-1:0] value);
      case (idx)
        mip_pkg::REG_SRC_WIDTH:  width_reg = value;
        mip_pkg::REG_SRC_HEIGHT: height_reg = value;
        mip_pkg::REG_BOX_MODE:   box_reg = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [mip_pkg::SizeW-1:0] v, int unsigned hi);
      if (v < mip_pkg::MinSize) return mip_pkg::MinSize;
      return (v > hi) ? hi : int'(v);
    endfunction

    function void note_pixel(mip_pkg::mip_in_t px);
      int unsigned                w, h, ow, oh, ox, oy, slot;
      logic [mip_pkg::ChanW-1:0]  cur [mip_pkg::NumChan];
      logic [mip_pkg::ChanW-1:0]  got [mip_pkg::NumChan];
      logic [mip_pkg::EntryW-1:0] entry;
      logic [11:0]                v;
      bit                         last_col, last_row;
      mip_pkg::mip_out_t          res;
      w    = clamp_dim(width_reg, TbMaxWidth);
      h    = clamp_dim(height_reg, mip_pkg::HeightLimit);
      ow   = w / 2;
      oh   = h / 2;
      ox   = col / 2;
      oy   = row / 2;
      slot = ox % StoreDepth;
      cur  = '{px.red, px.green, px.blue, px.alpha};
      last_col = (ox == ow - 1);
      last_row = (oy == oh - 1);
      if (col < 2 * ow && row < 2 * oh) begin
        if (col % 2 == 0) begin
          left_chan = cur;
        end else if (row % 2 == 0) begin
          entry = '0;
          for (int c = 0; c < mip_pkg::NumChan; c++) begin
            if (box_reg) begin
              entry[mip_pkg::FieldW*c +: mip_pkg::FieldW] =
                mip_pkg::FieldW'(left_chan[c]) + mip_pkg::FieldW'(cur[c]);
            end else begin
              entry[mip_pkg::FieldW*c +: mip_pkg::FieldW] =
                mip_pkg::FieldW'(last_col ? cur[c] : left_chan[c]);
            end
          end
          upper_row[slot] = entry;
        end else begin
          entry = upper_row[slot];
          for (int c = 0; c < mip_pkg::NumChan; c++) begin
            if (box_reg) begin
              v = (12'(entry[mip_pkg::FieldW*c +: mip_pkg::FieldW]) + 12'(left_chan[c]) +
                   12'(cur[c])) >> 2;
            end else if (last_row) begin
              v = 12'(last_col ? cur[c] : left_chan[c]);
            end else begin
              v = 12'(entry[mip_pkg::FieldW*c +: mip_pkg::FieldW]);
            end
            got[c] = v[mip_pkg::ChanW-1:0];
          end
          res.red_out    = got[0];
          res.green_out  = got[1];
          res.blue_out   = got[2];
          res.alpha_out  = got[3];
          res.last_pixel = last_col && last_row;
          pending_q.push_back(res);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_result(mip_pkg::mip_out_t got);
      mip_pkg::mip_out_t want;
      if (pending_q.size() == 0) begin
        if (mismatches < ShownMismatches) begin
          $display("unexpected output pixel r=%02h g=%02h b=%02h a=%02h last=%0b",
                   got.red_out, got.green_out, got.blue_out, got.alpha_out,
                   got.last_pixel);
        end
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
            got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out ||
            got.last_pixel !== want.last_pixel) begin
          if (mismatches < ShownMismatches) begin
            $display("mismatch: expected r=%02h g=%02h b=%02h a=%02h last=%0b",
                     want.red_out, want.green_out, want.blue_out, want.alpha_out,
                     want.last_pixel);
            $display("          actual   r=%02h g=%02h b=%02h a=%02h last=%0b",
                     got.red_out, got.green_out, got.blue_out, got.alpha_out,
                     got.last_pixel);
          end
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction
  endclass

  logic                         clk_i    = 1'b0;
  logic                         rst_ni;
  logic                         push     = 1'b0;
  logic                         full;
  mip_pkg::mip_in_t             pixel    = '0;
  logic                         empty;
  logic                         pop      = 1'b0;
  mip_pkg::mip_out_t            result;
  logic                         cfg_we   = 1'b0;
  logic [mip_pkg::CfgIdxW-1:0]  cfg_idx  = '0;
  logic [mip_pkg::SizeW-1:0]    cfg_data = '0;

  mip_scoreboard sb;
  int unsigned   send_idle_pct = 38;
  int unsigned   recv_idle_pct = 71;
  int unsigned   random_sent   = 0;
  int unsigned   stall_cycles  = 0;

  mip_level_downsampler_top #(
    .MAX_WIDTH(TbMaxWidth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .pixel_i   (pixel),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (pop && !empty) sb.check_result(result);
      if (stall_cycles >= StallLimit) begin
        $display("mip_level_downsampler_top verification failed");
        $finish;
      end
    end
  end

  function automatic mip_pkg::mip_in_t extreme_pixel();
    logic [mip_pkg::ChanW-1:0] ch [mip_pkg::NumChan];
    for (int c = 0; c < mip_pkg::NumChan; c++) begin
      case ($urandom_range(2))
        0:       ch[c] = '0;
        1:       ch[c] = '1;
        default: ch[c] = mip_pkg::ChanW'($urandom());
      endcase
    end
    return '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
  endfunction

  function automatic logic [mip_pkg::SizeW-1:0] rand_size();
    case ($urandom_range(19))
      0:       return mip_pkg::SizeW'(0);
      1:       return mip_pkg::SizeW'(1);
      2, 3:    return mip_pkg::SizeW'($urandom_range(40, 13));
      default: return mip_pkg::SizeW'($urandom_range(12, 2));
    endcase
  endfunction

  task automatic send_pixel(input mip_pkg::mip_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push  <= 1'b1;
    pixel <= px;
    do @(posedge clk_i); while (full);
    sb.note_pixel(px);
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input mip_pkg::mip_reg_e idx,
                           input logic [mip_pkg::SizeW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // A frame ends when the source position wraps back to the origin.
  task automatic send_frame(input int unsigned event_at, input bit extremes,
                            input bit counted);
    int unsigned sent;
    sent = 0;
    do begin
      if (event_at != 0 && sent == event_at) begin
        drain_and_settle();
        if ($urandom_range(1)) begin
          write_reg(mip_pkg::REG_BOX_MODE, mip_pkg::SizeW'($urandom_range(1)));
        end else begin
          write_reg(mip_pkg::REG_SRC_HEIGHT, mip_pkg::SizeW'($urandom_range(12)));
        end
      end
      send_pixel(extremes ? extreme_pixel() : mip_pkg::mip_in_t'($urandom()));
      sent++;
      if (counted) begin
        random_sent++;
        if (random_sent >= 2 * RandomPixels / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end else if (random_sent >= RandomPixels / 3) begin
          send_idle_pct = 71;
          recv_idle_pct = 38;
        end
      end
    end while (!sb.at_frame_start());
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned event_at;
    sb = new();
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_frame(0, 1'b1, 1'b0);
    drain_and_settle();
    write_reg(mip_pkg::REG_SRC_WIDTH, mip_pkg::SizeW'(0));
    write_reg(mip_pkg::REG_SRC_HEIGHT, mip_pkg::SizeW'(1));
    write_reg(mip_pkg::REG_BOX_MODE, mip_pkg::SizeW'(0));
    send_frame(0, 1'b1, 1'b0);
    drain_and_settle();
    write_reg(mip_pkg::REG_SRC_WIDTH, mip_pkg::SizeW'(5));
    write_reg(mip_pkg::REG_SRC_HEIGHT, mip_pkg::SizeW'(3));
    send_frame(0, 1'b1, 1'b0);

    frame_no = 0;
    while (random_sent < RandomPixels) begin
      if (frame_no == 3) begin
        drain_and_settle();
        write_reg(mip_pkg::REG_SRC_WIDTH, '1);
        write_reg(mip_pkg::REG_SRC_HEIGHT, mip_pkg::SizeW'(2));
        write_reg(mip_pkg::REG_BOX_MODE, mip_pkg::SizeW'(1));
        repeat (9) send_pixel(mip_pkg::mip_in_t'($urandom()));
        drain_and_settle();
        write_reg(mip_pkg::REG_SRC_WIDTH, mip_pkg::SizeW'(6));
        send_frame(0, 1'b0, 1'b0);
      end else if (frame_no == 8) begin
        drain_and_settle();
        write_reg(mip_pkg::REG_SRC_WIDTH, mip_pkg::SizeW'(3));
        write_reg(mip_pkg::REG_SRC_HEIGHT, '1);
        write_reg(mip_pkg::REG_BOX_MODE, mip_pkg::SizeW'(0));
        repeat (18) send_pixel(mip_pkg::mip_in_t'($urandom()));
        drain_and_settle();
        write_reg(mip_pkg::REG_SRC_HEIGHT, mip_pkg::SizeW'(4));
        send_frame(0, 1'b0, 1'b0);
      end else begin
        if (frame_no == 0 || frame_no == 4 || frame_no == 9 || $urandom_range(2) == 0) begin
          drain_and_settle();
          write_reg(mip_pkg::REG_SRC_WIDTH, rand_size());
          write_reg(mip_pkg::REG_SRC_HEIGHT, rand_size());
          write_reg(mip_pkg::REG_BOX_MODE, mip_pkg::SizeW'($urandom_range(1)));
        end
        event_at = ($urandom_range(5) == 0) ? $urandom_range(20, 1) : 0;
        send_frame(event_at, 1'b0, 1'b1);
      end
      frame_no++;
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("mip_level_downsampler_top verification clean");
    end else begin
      $display("mip_level_downsampler_top verification failed");
    end
    $finish;
  end

endmodule
